### hdl/med_pkg.sv
// types, character codes and limits shared by the entity decoder files
`timescale 1ns / 1ps

package med_pkg;

  localparam int CU_W = 16;
  localparam int CP_W = 21;

  typedef logic [CU_W-1:0] med_unit_t;
  typedef logic [CP_W-1:0] med_cp_t;

  localparam med_unit_t UNIT_AMP  = 16'h0026;
  localparam med_unit_t UNIT_SEMI = 16'h003B;
  localparam med_unit_t UNIT_HASH = 16'h0023;
  localparam med_unit_t UNIT_0    = 16'h0030;
  localparam med_unit_t UNIT_9    = 16'h0039;
  localparam med_unit_t UNIT_A_UP = 16'h0041;
  localparam med_unit_t UNIT_F_UP = 16'h0046;
  localparam med_unit_t UNIT_X_UP = 16'h0058;
  localparam med_unit_t UNIT_A_LO = 16'h0061;
  localparam med_unit_t UNIT_B_LO = 16'h0062;
  localparam med_unit_t UNIT_F_LO = 16'h0066;
  localparam med_unit_t UNIT_G_LO = 16'h0067;
  localparam med_unit_t UNIT_L_LO = 16'h006C;
  localparam med_unit_t UNIT_M_LO = 16'h006D;
  localparam med_unit_t UNIT_N_LO = 16'h006E;
  localparam med_unit_t UNIT_O_LO = 16'h006F;
  localparam med_unit_t UNIT_P_LO = 16'h0070;
  localparam med_unit_t UNIT_Q_LO = 16'h0071;
  localparam med_unit_t UNIT_S_LO = 16'h0073;
  localparam med_unit_t UNIT_T_LO = 16'h0074;
  localparam med_unit_t UNIT_U_LO = 16'h0075;
  localparam med_unit_t UNIT_X_LO = 16'h0078;

  localparam med_cp_t CP_AMP   = 21'h000026;
  localparam med_cp_t CP_LT    = 21'h00003C;
  localparam med_cp_t CP_GT    = 21'h00003E;
  localparam med_cp_t CP_QUOT  = 21'h000022;
  localparam med_cp_t CP_APOS  = 21'h000027;
  localparam med_cp_t CP_NBSP  = 21'h0000A0;
  localparam med_cp_t CP_LIMIT = 21'h10FFFF;
  localparam med_cp_t CP_SAT   = 21'h110000;
  localparam med_cp_t SURR_LO  = 21'h00D800;
  localparam med_cp_t SURR_HI  = 21'h00DFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DROP,
    ST_FLUSH,
    ST_DONE
  } med_state_t;

  typedef struct packed {
    logic    emit;
    logic    finish;
    med_cp_t cp;
  } med_emit_t;

  typedef struct packed {
    logic    ok;
    med_cp_t acc;
  } med_digit_t;

endpackage

### hdl/med_in_if.sv
// request channel carrying one text code unit and the end-of-text mark
`timescale 1ns / 1ps

interface med_in_if;
  import med_pkg::*;

  logic      valid;
  logic      ready;
  med_unit_t code_unit;
  logic      end_of_text;

  modport source(output valid, code_unit, end_of_text, input ready);
  modport sink(input valid, code_unit, end_of_text, output ready);
endinterface

### hdl/med_out_if.sv
// request channel carrying one decoded code point and the last-of-run mark
`timescale 1ns / 1ps

interface med_out_if;
  import med_pkg::*;

  logic    valid;
  logic    ready;
  med_cp_t code_point;
  logic    last_of_run;

  modport source(output valid, code_point, last_of_run, input ready);
  modport sink(input valid, code_point, last_of_run, output ready);
endinterface

### hdl/markup_entity_decoder.sv
// entity decoder top level: unit buffer, sequencer and reference matching
// a unit is accepted only while the sequencer is idle; each result passes the holding register
// and then the output register. Buffered units are rescanned after a failed reference, dropped
// after a matched reference and flushed at end of text; the sequencer handles one buffered unit
// per cycle through the digit unit while the output register does not stall it
// reset: synchronous rst clears the sequencer, counts, open flag and output valid
`timescale 1ns / 1ps

module markup_entity_decoder #(
  parameter int MAX_REF_SPAN = 12
) (
  input  logic      clk,
  input  logic      rst,
  med_in_if.sink    text_in,
  med_out_if.source char_out
);
  import med_pkg::*;

  localparam int DEPTH = MAX_REF_SPAN + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  med_state_t  state, state_next;
  logic [CW-1:0] len, len_next;
  logic [CW-1:0] scan, scan_next;
  logic        ref_open, ref_open_next;
  logic        eot;

  med_unit_t   held [DEPTH];

  logic        num_ok;
  logic        hex;
  logic        has_digit;
  med_cp_t     acc;

  med_unit_t   cur;
  logic        at_end;
  logic        shift;
  logic        append;
  logic        accept;
  logic        go;
  logic        ref_ok;
  med_cp_t     ref_cp;
  logic        num_match;
  med_emit_t   req;
  med_digit_t  dig;

  assign text_in.ready = (state == ST_IDLE);
  assign accept        = text_in.valid && text_in.ready;
  assign cur           = held[scan[IW-1:0]];
  assign at_end        = (scan == len);

  med_digit_acc u_digit (
    .unit (cur),
    .hex  (hex),
    .acc  (acc),
    .res  (dig)
  );

  med_result_stage u_result (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .go       (go),
    .char_out (char_out)
  );

  // body match at the closing semicolon
  always_comb begin
    num_match = (scan >= CW'(2)) && num_ok && has_digit && (acc != '0) &&
                (acc <= CP_LIMIT) && !(acc >= SURR_LO && acc <= SURR_HI);
    ref_ok = 1'b1;
    ref_cp = '0;
    if (scan == CW'(4) && held[1] == UNIT_A_LO && held[2] == UNIT_M_LO &&
        held[3] == UNIT_P_LO) begin
      ref_cp = CP_AMP;
    end else if (scan == CW'(3) && held[1] == UNIT_L_LO && held[2] == UNIT_T_LO) begin
      ref_cp = CP_LT;
    end else if (scan == CW'(3) && held[1] == UNIT_G_LO && held[2] == UNIT_T_LO) begin
      ref_cp = CP_GT;
    end else if (scan == CW'(5) && held[1] == UNIT_Q_LO && held[2] == UNIT_U_LO &&
                 held[3] == UNIT_O_LO && held[4] == UNIT_T_LO) begin
      ref_cp = CP_QUOT;
    end else if (scan == CW'(5) && held[1] == UNIT_A_LO && held[2] == UNIT_P_LO &&
                 held[3] == UNIT_O_LO && held[4] == UNIT_S_LO) begin
      ref_cp = CP_APOS;
    end else if (scan == CW'(5) && held[1] == UNIT_N_LO && held[2] == UNIT_B_LO &&
                 held[3] == UNIT_S_LO && held[4] == UNIT_P_LO) begin
      ref_cp = CP_NBSP;
    end else if (num_match) begin
      ref_cp = acc;
    end else begin
      ref_ok = 1'b0;
    end
  end

  always_comb begin
    state_next    = state;
    len_next      = len;
    scan_next     = scan;
    ref_open_next = ref_open;
    shift         = 1'b0;
    append        = 1'b0;
    req           = '0;
    unique case (state)
      ST_IDLE: begin
        if (text_in.valid) begin
          len_next   = len + CW'(1);
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (at_end) begin
          state_next = (eot && ref_open) ? ST_FLUSH : ST_DONE;
        end else if (!ref_open) begin
          if (cur == UNIT_AMP) begin
            ref_open_next = 1'b1;
            scan_next     = CW'(1);
          end else begin
            req.emit = 1'b1;
            req.cp   = CP_W'(cur);
            shift    = 1'b1;
            len_next = len - CW'(1);
          end
        end else if (cur == UNIT_SEMI && ref_ok) begin
          req.emit   = 1'b1;
          req.cp     = ref_cp;
          state_next = ST_DROP;
        end else if (cur != UNIT_SEMI && scan < CW'(MAX_REF_SPAN)) begin
          append    = 1'b1;
          scan_next = scan + CW'(1);
        end else begin
          // failed reference: give out the ampersand, rescan from the unit after it
          req.emit      = 1'b1;
          req.cp        = CP_AMP;
          shift         = 1'b1;
          len_next      = len - CW'(1);
          scan_next     = '0;
          ref_open_next = 1'b0;
        end
      end
      ST_DROP: begin
        shift    = 1'b1;
        len_next = len - CW'(1);
        if (scan == '0) begin
          ref_open_next = 1'b0;
          state_next    = ST_SCAN;
        end else begin
          scan_next = scan - CW'(1);
        end
      end
      ST_FLUSH: begin
        req.emit = 1'b1;
        req.cp   = CP_W'(held[0]);
        shift    = 1'b1;
        len_next = len - CW'(1);
        if (len == CW'(1)) begin
          ref_open_next = 1'b0;
          scan_next     = '0;
          state_next    = ST_DONE;
        end
      end
      ST_DONE: begin
        req.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      len      <= '0;
      scan     <= '0;
      ref_open <= 1'b0;
      eot      <= 1'b0;
    end else if (go) begin
      state    <= state_next;
      len      <= len_next;
      scan     <= scan_next;
      ref_open <= ref_open_next;
      if (accept) begin
        eot <= text_in.end_of_text;
      end
    end
  end

  // unit buffer: new unit at the tail, consumed units leave from the head
  always_ff @(posedge clk) begin
    if (accept) begin
      held[len[IW-1:0]] <= text_in.code_unit;
    end else if (go && shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        held[i] <= held[i+1];
      end
    end
  end

  // numeric body tracking, one appended unit per cycle while the sequencer is not stalled
  always_ff @(posedge clk) begin
    if (go && append) begin
      if (scan == CW'(1)) begin
        num_ok    <= (cur == UNIT_HASH);
        hex       <= 1'b0;
        has_digit <= 1'b0;
        acc       <= '0;
      end else if (scan == CW'(2) && (cur == UNIT_X_LO || cur == UNIT_X_UP)) begin
        hex <= 1'b1;
      end else if (!dig.ok) begin
        num_ok <= 1'b0;
      end else begin
        acc       <= dig.acc;
        has_digit <= 1'b1;
      end
    end
  end

endmodule

### hdl/med_digit_acc.sv
// digit unit: decodes one decimal or hex digit and accumulates it with saturation
`timescale 1ns / 1ps

module med_digit_acc (
  input  med_pkg::med_unit_t  unit,
  input  logic                hex,
  input  med_pkg::med_cp_t    acc,
  output med_pkg::med_digit_t res
);
  import med_pkg::*;

  localparam int SW = CP_W + 4;

  logic          is_digit;
  logic [3:0]    digit;
  logic [SW-1:0] scaled;
  logic [SW-1:0] total;

  always_comb begin
    is_digit = 1'b0;
    digit    = '0;
    if (unit >= UNIT_0 && unit <= UNIT_9) begin
      is_digit = 1'b1;
      digit    = 4'(unit - UNIT_0);
    end else if (hex && unit >= UNIT_A_LO && unit <= UNIT_F_LO) begin
      is_digit = 1'b1;
      digit    = 4'(unit - UNIT_A_LO + 16'd10);
    end else if (hex && unit >= UNIT_A_UP && unit <= UNIT_F_UP) begin
      is_digit = 1'b1;
      digit    = 4'(unit - UNIT_A_UP + 16'd10);
    end
  end

  // times 16 or times 10 as shift and add
  always_comb begin
    if (hex) begin
      scaled = {acc, 4'b0000};
    end else begin
      scaled = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0};
    end
    total = scaled + SW'(digit);
  end

  always_comb begin
    res.ok  = is_digit;
    res.acc = (total > SW'(CP_LIMIT)) ? CP_SAT : total[CP_W-1:0];
  end

endmodule

### hdl/med_result_stage.sv
// result holding register and output register, marks the last result of each run
`timescale 1ns / 1ps

module med_result_stage (
  input  logic               clk,
  input  logic               rst,
  input  med_pkg::med_emit_t req,
  output logic               go,
  med_out_if.source          char_out
);
  import med_pkg::*;

  logic    out_valid;
  med_cp_t out_cp;
  logic    out_last;
  logic    hold_valid;
  med_cp_t hold_cp;
  logic    out_free;
  logic    push;

  assign out_free = !out_valid || char_out.ready;
  assign push     = hold_valid && (req.emit || req.finish);
  assign go       = !push || out_free;

  assign char_out.valid       = out_valid;
  assign char_out.code_point  = out_cp;
  assign char_out.last_of_run = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (go && push) begin
        out_valid <= 1'b1;
      end else if (char_out.ready) begin
        out_valid <= 1'b0;
      end
      if (go && req.emit) begin
        hold_valid <= 1'b1;
      end else if (go && req.finish) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && push) begin
      out_cp   <= hold_cp;
      out_last <= req.finish;
    end
    if (go && req.emit) begin
      hold_cp <= req.cp;
    end
  end

endmodule
